// ----- design/rau_pkg.sv -----
// rau_pkg: types and constants shared by the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [1:0] MUL_P0 = 2'd0;
   localparam logic [1:0] MUL_P1 = 2'd1;
   localparam logic [1:0] MUL_P2 = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_GINIT,
      S_GCD,
      S_DINIT,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div0;
      logic zero;
      logic gcd_done;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

// ----- design/rau_dp.sv -----
// rau_dp: datapath with shared multiplier, binary gcd and shift-subtract divider
// depends on rau_pkg
`default_nettype none
module rau_dp #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire rau_pkg::cmd_type cmd,
   output rau_pkg::stat_type     stat,
   input  wire logic [1:0]       in_kind,
   input  wire logic [31:0]      in_a_num,
   input  wire logic [30:0]      in_a_den,
   input  wire logic [31:0]      in_b_num,
   input  wire logic [30:0]      in_b_den,
   output logic [31:0]           res_num,
   output logic [30:0]           res_den,
   output logic [1:0]            status
);
   localparam int W = (OPERAND_WIDTH > 32) ? 32 : ((OPERAND_WIDTH < 8) ? 8 : OPERAND_WIDTH);
   localparam logic [63:0] LIM = 64'd1 << (W - 1);

   logic [1:0]         kind_ff;
   logic signed [31:0] an_ff, bn_ff, ad_ff, bd_ff;
   logic               div0_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff;
   logic signed [63:0] n_ff, d_ff;
   logic [63:0]        u_ff, v_ff;
   logic [5:0]         k_ff;
   logic               neg_ff, zero_ff;
   logic [63:0]        nq_ff, dq_ff, rn_ff, rd_ff, g_ff;
   logic [6:0]         cnt_ff;
   logic [31:0]        res_num_ff;
   logic [30:0]        res_den_ff;
   logic [1:0]         status_ff;

   logic signed [31:0] ma, mb;
   logic signed [63:0] prod, sum_n;
   logic [64:0]        rn_sh, rd_sh;
   logic [64:0]        rn_sub, rd_sub;
   logic [63:0]        mag, dm, udiff, vdiff;
   logic               ovf;

   always_comb begin
      case (cmd.mul_sel)
         rau_pkg::MUL_P0: begin
            ma = an_ff;
            mb = (kind_ff == rau_pkg::KIND_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::MUL_P1: begin
            ma = bn_ff;
            mb = ad_ff;
         end
         default: begin
            ma = ad_ff;
            mb = (kind_ff == rau_pkg::KIND_DIV) ? bn_ff : bd_ff;
         end
      endcase
      prod = ma * mb;
   end

   always_comb begin
      case (kind_ff)
         rau_pkg::KIND_ADD: sum_n = p0_ff + p1_ff;
         rau_pkg::KIND_SUB: sum_n = p0_ff - p1_ff;
         default:           sum_n = p0_ff;
      endcase
   end

   assign mag   = n_ff[63] ? (64'd0 - n_ff) : n_ff;
   assign dm    = d_ff;
   assign udiff = u_ff - v_ff;
   assign vdiff = v_ff - u_ff;
   assign rn_sh = {rn_ff, nq_ff[63]};
   assign rd_sh = {rd_ff, dq_ff[63]};
   assign rn_sub = rn_sh - {1'b0, g_ff};
   assign rd_sub = rd_sh - {1'b0, g_ff};

   assign ovf = (dq_ff > LIM - 64'd1) || (neg_ff ? (nq_ff > LIM) : (nq_ff > LIM - 64'd1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind;
         an_ff   <= in_a_num;
         bn_ff   <= in_b_num;
         ad_ff   <= {1'b0, in_a_den};
         bd_ff   <= {1'b0, in_b_den};
         div0_ff <= (in_a_den == 31'd0) || (in_b_den == 31'd0) ||
                    ((in_kind == rau_pkg::KIND_DIV) && (in_b_num == 32'd0));
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            rau_pkg::MUL_P0: p0_ff <= prod;
            rau_pkg::MUL_P1: p1_ff <= prod;
            default:         p2_ff <= prod;
         endcase
      end
      if (cmd.sum) begin
         n_ff <= p2_ff[63] ? (64'sd0 - sum_n) : sum_n;
         d_ff <= p2_ff[63] ? (64'sd0 - p2_ff) : p2_ff;
      end
      if (cmd.gcd_init) begin
         neg_ff  <= n_ff[63];
         zero_ff <= (n_ff == 64'sd0);
         u_ff    <= mag;
         v_ff    <= dm;
         nq_ff   <= mag;
         dq_ff   <= dm;
         k_ff    <= 6'd0;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 6'd1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= udiff;
         end else begin
            v_ff <= vdiff;
         end
      end
      if (cmd.div_init) begin
         g_ff   <= (u_ff | v_ff) << k_ff;
         rn_ff  <= 64'd0;
         rd_ff  <= 64'd0;
         cnt_ff <= 7'd0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 7'd1;
         if (!rn_sub[64]) begin
            rn_ff <= rn_sub[63:0];
            nq_ff <= {nq_ff[62:0], 1'b1};
         end else begin
            rn_ff <= rn_sh[63:0];
            nq_ff <= {nq_ff[62:0], 1'b0};
         end
         if (!rd_sub[64]) begin
            rd_ff <= rd_sub[63:0];
            dq_ff <= {dq_ff[62:0], 1'b1};
         end else begin
            rd_ff <= rd_sh[63:0];
            dq_ff <= {dq_ff[62:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         if (div0_ff) begin
            res_num_ff <= 32'd0;
            res_den_ff <= 31'd0;
            status_ff  <= rau_pkg::ST_DIV0;
         end else if (zero_ff) begin
            res_num_ff <= 32'd0;
            res_den_ff <= 31'd1;
            status_ff  <= rau_pkg::ST_OK;
         end else if (ovf) begin
            res_num_ff <= 32'd0;
            res_den_ff <= 31'd0;
            status_ff  <= rau_pkg::ST_OVF;
         end else begin
            res_num_ff <= neg_ff ? (32'd0 - nq_ff[31:0]) : nq_ff[31:0];
            res_den_ff <= dq_ff[30:0];
            status_ff  <= rau_pkg::ST_OK;
         end
      end
   end

   assign stat.div0     = div0_ff;
   assign stat.zero     = (n_ff == 64'sd0);
   assign stat.gcd_done = (u_ff == 64'd0) || (v_ff == 64'd0);
   assign stat.div_done = cnt_ff[6];

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status  = status_ff;
endmodule
`default_nettype wire

// ----- design/rau_ctrl.sv -----
// rau_ctrl: sequencer for the rational arithmetic unit and result valid flag
// depends on rau_pkg
`default_nettype none
module rau_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire rau_pkg::stat_type stat,
   output rau_pkg::cmd_type       cmd
);
   rau_pkg::state_type state_ff, state_in;
   logic               valid_ff, valid_in;
   logic               out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == rau_pkg::S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::S_IDLE:  if (req_tvalid) state_in = rau_pkg::S_CHECK;
         rau_pkg::S_CHECK: state_in = stat.div0 ? rau_pkg::S_DONE : rau_pkg::S_MUL0;
         rau_pkg::S_MUL0:  state_in = rau_pkg::S_MUL1;
         rau_pkg::S_MUL1:  state_in = rau_pkg::S_MUL2;
         rau_pkg::S_MUL2:  state_in = rau_pkg::S_SUM;
         rau_pkg::S_SUM:   state_in = rau_pkg::S_GINIT;
         rau_pkg::S_GINIT: state_in = stat.zero ? rau_pkg::S_DONE : rau_pkg::S_GCD;
         rau_pkg::S_GCD:   if (stat.gcd_done) state_in = rau_pkg::S_DINIT;
         rau_pkg::S_DINIT: state_in = rau_pkg::S_DIV;
         rau_pkg::S_DIV:   if (stat.div_done) state_in = rau_pkg::S_DONE;
         rau_pkg::S_DONE:  if (out_free) state_in = rau_pkg::S_IDLE;
         default:          state_in = rau_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = rau_pkg::MUL_P0;
      case (state_ff)
         rau_pkg::S_IDLE:  cmd.load = req_tvalid;
         rau_pkg::S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rau_pkg::MUL_P0;
         end
         rau_pkg::S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rau_pkg::MUL_P1;
         end
         rau_pkg::S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rau_pkg::MUL_P2;
         end
         rau_pkg::S_SUM:   cmd.sum = 1'b1;
         rau_pkg::S_GINIT: cmd.gcd_init = 1'b1;
         rau_pkg::S_GCD:   cmd.gcd_step = !stat.gcd_done;
         rau_pkg::S_DINIT: cmd.div_init = 1'b1;
         rau_pkg::S_DIV:   cmd.div_step = !stat.div_done;
         rau_pkg::S_DONE:  cmd.out_load = out_free;
         default:          cmd = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (cmd.out_load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
// rational_arithmetic_unit: top level, add/sub/mul/div of rationals with gcd reduction
// depends on rau_pkg, rau_ctrl, rau_dp
//
//   channel  dir  payload
//   req_*    in   tuser kind, tdata a_num a_den b_num b_den
//   rsp_*    out  tuser status, tdata res_num res_den
//
// an item passes the checks, then three multiplies, a sum, the binary gcd loop
// (one shift or subtract per cycle) and the shift-subtract divider that divides
// both parts by the gcd; zero-numerator items skip gcd and divider
// a division by zero or a zero denominator ends the item right after the checks
// reset clears the sequencer and the result valid flag
// a held result stalls the next item only in its done state, before its result is loaded
`default_nettype none
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den, zero pad
   input  wire logic [1:0]   req_tuser,  // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // res_num, res_den, zero pad
   output logic [1:0]        rsp_tuser   // status
);
   rau_pkg::cmd_type  cmd;
   rau_pkg::stat_type stat;
   logic [31:0]       res_num;
   logic [30:0]       res_den;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rau_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .stat     (stat),
      .in_kind  (req_tuser),
      .in_a_num (req_tdata[31:0]),
      .in_a_den (req_tdata[62:32]),
      .in_b_num (req_tdata[94:63]),
      .in_b_den (req_tdata[125:95]),
      .res_num  (res_num),
      .res_den  (res_den),
      .status   (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, res_den, res_num};
endmodule
`default_nettype wire
